// File: design/spd_pkg.sv
// ============================================================================
// spd_pkg - shared types and constants of the status packet deframer
// Holds the sync byte values, payload offsets, bumper masks and the
// decoded status record.
// ============================================================================
package spd_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    // Packet offsets that are kept in the payload store.
    localparam int PAYLOAD_FIRST = 2;
    localparam int PAYLOAD_LAST  = 11;
    localparam int STORE_DEPTH   = PAYLOAD_LAST - PAYLOAD_FIRST + 1;

    // Packet offsets of the decoded fields.
    localparam int OFS_ENC_LEFT  = 2;
    localparam int OFS_ENC_RIGHT = 4;
    localparam int OFS_BAT_WIDTH = 6;
    localparam int OFS_BAT_PERIOD = 8;
    localparam int OFS_BUMPERS   = 10;
    localparam int OFS_MOTION    = 11;

    // Bumper bits in the flag byte; a bumper is pressed when its bit is clear.
    localparam logic [7:0] MASK_FRONT_LEFT  = 8'h01;
    localparam logic [7:0] MASK_FRONT_RIGHT = 8'h02;
    localparam logic [7:0] MASK_REAR_LEFT   = 8'h10;
    localparam logic [7:0] MASK_REAR_RIGHT  = 8'h20;

    typedef struct packed {
        logic signed [15:0] enc_left_delta;
        logic signed [15:0] enc_right_delta;
        logic [15:0]        battery_pulse_width;
        logic [15:0]        battery_pulse_period;
        logic               bumper_front_left;
        logic               bumper_front_right;
        logic               bumper_rear_left;
        logic               bumper_rear_right;
        logic [7:0]         motion_state;
    } status_t;

endpackage

// File: design/status_packet_deframer.sv
// ============================================================================
// status_packet_deframer - sync hunt and status decode for a byte stream
// Finds the 0xAA 0x55 sync pair, gathers one fixed-length packet and emits
// one decoded status item on the last byte of every packet.
// ============================================================================
// Usage:
// The input channel (rx_byte, in_valid, in_stall) carries one received byte
// per item. The output channel (out_valid, out_stall and the status fields)
// carries one decoded status item per packet. An item moves on a rising
// edge where valid is high and stall is low.
// Throughput is one byte per cycle while in_stall is low: the sync tracker,
// position counter and field decode are a single short step between the
// accepted byte and the result register. When the last byte of a packet is
// accepted, its item is registered into the result register, or into the
// skid register if the result register is stalled. The two-entry output
// stage lets the block keep taking bytes while a finished item waits on
// out_stall. Only when both entries hold items does in_stall rise; it is
// driven from a register, so it never depends combinationally on out_stall.
// Reset puts the block into hunting for the first sync byte and empties
// both output entries. After lock, sync is never checked again; the block
// simply counts PACKET_BYTES bytes per packet.
// ============================================================================
module status_packet_deframer
    import spd_pkg::*;
#(
    parameter int PACKET_BYTES = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] enc_left_delta,
    output logic signed [15:0] enc_right_delta,
    output logic [15:0]        battery_pulse_width,
    output logic [15:0]        battery_pulse_period,
    output logic               bumper_front_left,
    output logic               bumper_front_right,
    output logic               bumper_rear_left,
    output logic               bumper_rear_right,
    output logic [7:0]         motion_state
);

    // Wide enough for the last offset, PACKET_BYTES-1.
    localparam int POS_W = $clog2(PACKET_BYTES);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(PACKET_BYTES - 1);
    localparam logic [POS_W-1:0] POS_START = POS_W'(PAYLOAD_FIRST);

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_EXPECT = 2'd1,
        PH_LOCKED = 2'd2
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        store_reg [STORE_DEPTH];
    status_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    status_t           skid_reg, skid_next;
    logic              skid_valid_reg, skid_valid_next;

    logic              in_fire;
    logic              out_fire;
    logic              last_byte;
    logic              produce;
    logic [7:0]        view [STORE_DEPTH];
    logic [7:0]        flags;
    status_t           result;

    assign in_fire  = in_valid & ~in_stall;
    assign out_fire = out_valid_reg & ~out_stall;
    assign in_stall = skid_valid_reg;

    assign last_byte = (phase_reg == PH_LOCKED) && (pos_reg == POS_LAST);
    assign produce   = in_fire & last_byte;

    // The packet as the result sees it: the store, with the byte being
    // accepted now standing in for its own entry (it may be the last one).
    always_comb
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            view[i] = store_reg[i];
            if ((phase_reg == PH_LOCKED) && (pos_reg == POS_W'(PAYLOAD_FIRST + i)))
            begin
                view[i] = rx_byte;
            end
        end
    end

    assign flags = view[OFS_BUMPERS - PAYLOAD_FIRST];

    always_comb
    begin
        result.enc_left_delta = {view[OFS_ENC_LEFT + 1 - PAYLOAD_FIRST],
                                 view[OFS_ENC_LEFT - PAYLOAD_FIRST]};
        result.enc_right_delta = {view[OFS_ENC_RIGHT + 1 - PAYLOAD_FIRST],
                                  view[OFS_ENC_RIGHT - PAYLOAD_FIRST]};
        result.battery_pulse_width = {view[OFS_BAT_WIDTH + 1 - PAYLOAD_FIRST],
                                      view[OFS_BAT_WIDTH - PAYLOAD_FIRST]};
        result.battery_pulse_period = {view[OFS_BAT_PERIOD + 1 - PAYLOAD_FIRST],
                                       view[OFS_BAT_PERIOD - PAYLOAD_FIRST]};
        result.bumper_front_left  = ((flags & MASK_FRONT_LEFT) == 8'h00);
        result.bumper_front_right = ((flags & MASK_FRONT_RIGHT) == 8'h00);
        result.bumper_rear_left   = ((flags & MASK_REAR_LEFT) == 8'h00);
        result.bumper_rear_right  = ((flags & MASK_REAR_RIGHT) == 8'h00);
        result.motion_state = view[OFS_MOTION - PAYLOAD_FIRST];
    end

    // Sync tracking and packet position.
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        if (in_fire)
        begin
            unique case (phase_reg)
                PH_EXPECT:
                begin
                    if (rx_byte == SYNC_SECOND)
                    begin
                        phase_next = PH_LOCKED;
                        pos_next   = POS_START;
                    end
                    else if (rx_byte != SYNC_FIRST)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_LOCKED:
                begin
                    if (pos_reg == POS_LAST)
                    begin
                        pos_next = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                default:
                begin
                    // Hunting, and the unused phase code behaves the same.
                    phase_next = (rx_byte == SYNC_FIRST) ? PH_EXPECT : PH_HUNT;
                end
            endcase
        end
    end

    // Output stage: the result register feeds the port, the skid register
    // catches an item that completes while the result register is stalled.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = result;
                out_valid_next = produce;
            end
        end
        else if (produce)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
        if (in_fire)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                if ((phase_reg == PH_LOCKED) && (pos_reg == POS_W'(PAYLOAD_FIRST + i)))
                begin
                    store_reg[i] <= rx_byte;
                end
            end
        end
    end

    assign out_valid            = out_valid_reg;
    assign enc_left_delta       = out_reg.enc_left_delta;
    assign enc_right_delta      = out_reg.enc_right_delta;
    assign battery_pulse_width  = out_reg.battery_pulse_width;
    assign battery_pulse_period = out_reg.battery_pulse_period;
    assign bumper_front_left    = out_reg.bumper_front_left;
    assign bumper_front_right   = out_reg.bumper_front_right;
    assign bumper_rear_left     = out_reg.bumper_rear_left;
    assign bumper_rear_right    = out_reg.bumper_rear_right;
    assign motion_state         = out_reg.motion_state;

    // The skid register only fills behind a full result register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register is empty");

    // A packet that ends while the result register is stalled is kept.
    a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("completed status item dropped under stall");

    // The packet position never passes the last offset.
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LOCKED) |-> (pos_reg <= POS_LAST))
        else $error("packet position out of range");

endmodule

// File: tb/status_packet_deframer_test.sv
// ============================================================================
// status_packet_deframer_test - self-checking bench for the status deframer
// Feeds received bytes through the valid/stall input channel and checks
// every decoded status item against a hand-written item (the directed
// packets) or a local model of the sync hunt, the packet offset counter and
// the field decode. A short directed table covers the sync corner cases and
// field extremes; random bytes follow once locked. Both channels idle at random.
// ============================================================================
module status_packet_deframer_test;
    import spd_pkg::*;

    localparam int PACKET_BYTES    = 12;
    localparam int DIRECTED_COUNT  = 28;
    localparam int RANDOM_COUNT    = 800;
    localparam int MAX_IDLE        = 18;
    localparam int DRAIN_CYCLES    = 40;
    localparam int LIMIT_CYCLES    = 200_000;

    // Sync tracker states of the local model.
    typedef enum logic [1:0] {
        HUNT,
        WAIT_SECOND,
        LOCKED
    } sync_state_t;

    // One row of the directed stimulus. When typed is set, want holds the
    // status item that this byte must complete, written out by hand.
    typedef struct {
        logic [7:0] data;
        bit         typed;
        status_t    want;
    } stim_row_t;

    // First packet after sync: most negative left delta, most positive right
    // delta, full-scale width, zero period, every bumper pressed.
    localparam status_t PACKET_A_STATUS = '{
        enc_left_delta:       16'sh8000,
        enc_right_delta:      16'sh7FFF,
        battery_pulse_width:  16'hFFFF,
        battery_pulse_period: 16'h0000,
        bumper_front_left:    1'b1,
        bumper_front_right:   1'b1,
        bumper_rear_left:     1'b1,
        bumper_rear_right:    1'b1,
        motion_state:         8'hFF
    };

    // Second packet: the mirror image, no bumper pressed.
    localparam status_t PACKET_B_STATUS = '{
        enc_left_delta:       16'sh7FFF,
        enc_right_delta:      16'sh8000,
        battery_pulse_width:  16'h0000,
        battery_pulse_period: 16'hFFFF,
        bumper_front_left:    1'b0,
        bumper_front_right:   1'b0,
        bumper_rear_left:     1'b0,
        bumper_rear_right:    1'b0,
        motion_state:         8'h00
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] enc_left_delta;
    logic signed [15:0] enc_right_delta;
    logic [15:0]        battery_pulse_width;
    logic [15:0]        battery_pulse_period;
    logic               bumper_front_left;
    logic               bumper_front_right;
    logic               bumper_rear_left;
    logic               bumper_rear_right;
    logic [7:0]         motion_state;

    // Local copy of the deframer state.
    sync_state_t sync_state = HUNT;
    logic [5:0]  packet_offset = '0;
    logic [7:0]  packet_bytes [PAYLOAD_FIRST:PAYLOAD_LAST];

    // Status items still owed by the block, oldest first.
    status_t     pending_status [$];

    // Side information that travels with the byte on the input channel.
    bit          row_typed = 1'b0;
    status_t     row_want = '0;

    stim_row_t   directed_rows [DIRECTED_COUNT];
    int          mismatches = 0;
    int          results_taken = 0;
    int          results_seen = 0;
    int          recv_hold = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;
    bit          produced;
    status_t     predicted;

    status_packet_deframer #(
        .PACKET_BYTES(PACKET_BYTES)
    ) DUT (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .rx_byte              (rx_byte),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .enc_left_delta       (enc_left_delta),
        .enc_right_delta      (enc_right_delta),
        .battery_pulse_width  (battery_pulse_width),
        .battery_pulse_period (battery_pulse_period),
        .bumper_front_left    (bumper_front_left),
        .bumper_front_right   (bumper_front_right),
        .bumper_rear_left     (bumper_rear_left),
        .bumper_rear_right    (bumper_rear_right),
        .motion_state         (motion_state)
    );

    always #2 clk = ~clk;

    // Little-endian 16-bit word from two stored packet offsets.
    function automatic logic [15:0] le16(input int first_offset);
        return {packet_bytes[first_offset + 1], packet_bytes[first_offset]};
    endfunction

    // Advances the local model by one received byte. Returns 1 when the byte
    // closes a packet, with the decoded status in item.
    function automatic bit take_byte(input logic [7:0] b, output status_t item);
        logic [7:0] flags;
        item = '0;
        case (sync_state)
            WAIT_SECOND:
            begin
                // A repeated 0xAA keeps waiting; anything else but 0x55
                // drops back to hunting.
                if (b == SYNC_SECOND)
                begin
                    sync_state = LOCKED;
                    packet_offset = 6'(PAYLOAD_FIRST);
                end
                else if (b != SYNC_FIRST)
                begin
                    sync_state = HUNT;
                end
                return 1'b0;
            end
            LOCKED:
            begin
                // Offsets 0 and 1 of later packets are counted only; sync is
                // never checked again once locked.
                if (packet_offset >= PAYLOAD_FIRST && packet_offset <= PAYLOAD_LAST)
                begin
                    packet_bytes[packet_offset] = b;
                end
                if (packet_offset < PACKET_BYTES - 1)
                begin
                    packet_offset = packet_offset + 1'b1;
                    return 1'b0;
                end
                packet_offset = '0;
                flags = packet_bytes[OFS_BUMPERS];
                item.enc_left_delta       = le16(OFS_ENC_LEFT);
                item.enc_right_delta      = le16(OFS_ENC_RIGHT);
                item.battery_pulse_width  = le16(OFS_BAT_WIDTH);
                item.battery_pulse_period = le16(OFS_BAT_PERIOD);
                item.bumper_front_left    = (flags & MASK_FRONT_LEFT) == 8'h00;
                item.bumper_front_right   = (flags & MASK_FRONT_RIGHT) == 8'h00;
                item.bumper_rear_left     = (flags & MASK_REAR_LEFT) == 8'h00;
                item.bumper_rear_right    = (flags & MASK_REAR_RIGHT) == 8'h00;
                item.motion_state         = packet_bytes[OFS_MOTION];
                return 1'b1;
            end
            default:
            begin
                sync_state = (b == SYNC_FIRST) ? WAIT_SECOND : HUNT;
                return 1'b0;
            end
        endcase
    endfunction

    // Random byte, weighted toward the values that make field extremes and
    // toward the sync values, which must pass as plain data once locked.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            4:       return SYNC_FIRST;
            5:       return SYNC_SECOND;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic compare_status(input status_t want);
        if (enc_left_delta !== want.enc_left_delta)
        begin
            $error("enc_left_delta: expected %0d, got %0d",
                   want.enc_left_delta, enc_left_delta);
            mismatches++;
        end
        if (enc_right_delta !== want.enc_right_delta)
        begin
            $error("enc_right_delta: expected %0d, got %0d",
                   want.enc_right_delta, enc_right_delta);
            mismatches++;
        end
        if (battery_pulse_width !== want.battery_pulse_width)
        begin
            $error("battery_pulse_width: expected %0d, got %0d",
                   want.battery_pulse_width, battery_pulse_width);
            mismatches++;
        end
        if (battery_pulse_period !== want.battery_pulse_period)
        begin
            $error("battery_pulse_period: expected %0d, got %0d",
                   want.battery_pulse_period, battery_pulse_period);
            mismatches++;
        end
        if (bumper_front_left !== want.bumper_front_left)
        begin
            $error("bumper_front_left: expected %0b, got %0b",
                   want.bumper_front_left, bumper_front_left);
            mismatches++;
        end
        if (bumper_front_right !== want.bumper_front_right)
        begin
            $error("bumper_front_right: expected %0b, got %0b",
                   want.bumper_front_right, bumper_front_right);
            mismatches++;
        end
        if (bumper_rear_left !== want.bumper_rear_left)
        begin
            $error("bumper_rear_left: expected %0b, got %0b",
                   want.bumper_rear_left, bumper_rear_left);
            mismatches++;
        end
        if (bumper_rear_right !== want.bumper_rear_right)
        begin
            $error("bumper_rear_right: expected %0b, got %0b",
                   want.bumper_rear_right, bumper_rear_right);
            mismatches++;
        end
        if (motion_state !== want.motion_state)
        begin
            $error("motion_state: expected %0d, got %0d",
                   want.motion_state, motion_state);
            mismatches++;
        end
    endtask

    // Offers one byte after a random idle gap and returns at the rising edge
    // where it is taken. The valid line is only lowered when a gap follows,
    // so back-to-back items keep it high without a glitch.
    task automatic send_byte(input logic [7:0] b, input bit typed, input status_t want);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if ($urandom_range(0, 63) == 0)
        begin
            send_burst = !send_burst;
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        rx_byte   <= b;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Takes the sender off the channel and waits until every owed status
    // item has been taken.
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Input side and output side are watched in one process, so the
    // expectation for a byte is always in place before its result can show.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                produced = take_byte(rx_byte, predicted);
                if (row_typed)
                begin
                    pending_status.push_back(row_want);
                end
                else if (produced)
                begin
                    pending_status.push_back(predicted);
                end
            end
            if (out_valid && !out_stall)
            begin
                if (pending_status.size() == 0)
                begin
                    $error("status item arrived with none expected");
                    mismatches++;
                end
                else
                begin
                    compare_status(pending_status.pop_front());
                end
                results_taken++;
            end
        end
    end

    // The receiver draws a new stall length after every item it takes. The
    // stall also runs while nothing is offered, and a burst mode switches it
    // off for stretches so the block also sees a free-running sink.
    always @(negedge clk)
    begin
        if (results_taken != results_seen)
        begin
            results_seen = results_taken;
            recv_hold = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
            if ($urandom_range(0, 63) == 0)
            begin
                recv_burst = !recv_burst;
            end
        end
        out_stall <= (recv_hold > 0);
        if (recv_hold > 0)
        begin
            recv_hold--;
        end
    end

    // Watchdog.
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int pause_at;

        // Hunting corner cases first: a repeated 0xAA, a wrong second byte,
        // a stray 0x55 while hunting, then a clean sync pair. Two packets
        // follow; the second starts with swapped sync bytes at offsets 0
        // and 1, which a locked block must take as plain data.
        directed_rows = '{
            '{8'hAA, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'h12, 1'b0, '0},
            '{8'h55, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'h55, 1'b0, '0},
            '{8'h00, 1'b0, '0}, '{8'h80, 1'b0, '0}, '{8'hFF, 1'b0, '0},
            '{8'h7F, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
            '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'hFF, 1'b1, PACKET_A_STATUS},
            '{8'h55, 1'b0, '0}, '{8'hAA, 1'b0, '0},
            '{8'hFF, 1'b0, '0}, '{8'h7F, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'h80, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
            '{8'h00, 1'b1, PACKET_B_STATUS}
        };

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].data, directed_rows[i].typed,
                      directed_rows[i].want);
        end

        // Random part. The stream stays locked from here on, so every
        // twelfth byte closes a packet. Once along the way the sender holds
        // off until the block has delivered everything it owes.
        pause_at = $urandom_range(RANDOM_COUNT / 4, 3 * RANDOM_COUNT / 4);
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if (n == pause_at)
            begin
                wait_for_results();
            end
            send_byte(pick_byte(), 1'b0, '0);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: files.f
design/spd_pkg.sv
design/status_packet_deframer.sv
tb/status_packet_deframer_test.sv
